// File: hw/rtl/rwim_pkg.sv
package rwim_pkg;

  // Snapshot geometry: bytes are spread over one bank per beat byte lane
  localparam int SNAP_BYTES = 64;
  localparam int BEAT_BYTES = 8;
  localparam int LANES      = 8;
  localparam int LANE_W     = $clog2(LANES);
  localparam int ROWS       = SNAP_BYTES / LANES;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int IDX_W      = ROW_W + LANE_W;

  // Field and register widths
  localparam int ADDR_W    = 64;
  localparam int DATA_W    = 64;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = 4;
  localparam int SUM_W     = 64;
  localparam int FRAMES_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSES_ONLY = 2'd2;

  // FNV-1a 64: prime is 2^40 + 435
  localparam logic [SUM_W-1:0] FNV_OFFSET   = 64'hCBF2_9CE4_8422_2325;
  localparam int               FNV_SHIFT    = 40;
  localparam logic [SUM_W-1:0] FNV_PRIME_LO = 64'd435;

  typedef struct packed {
    logic load;
    logic hash_start;
    logic merge_rd;
    logic merge_wr;
    logic hash_rd;
    logic hash_step;
    logic emit;
  } rwim_cmd_t;

  typedef struct packed {
    logic merge_ok;
    logic len_zero;
    logic hash_last;
    logic row_end;
    logic out_free;
  } rwim_status_t;

endpackage

// File: hw/rtl/rwim_ctrl.sv
module rwim_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic                   in_actuate,
  input  rwim_pkg::rwim_status_t status,
  output rwim_pkg::rwim_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MRD   = 3'd1;
  localparam logic [2:0] S_MWR   = 3'd2;
  localparam logic [2:0] S_HRD   = 3'd3;
  localparam logic [2:0] S_HBYTE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_act;
  logic       last_act_next;
  logic       close;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      last_act <= 1'b0;
    end else begin
      state    <= state_next;
      last_act <= last_act_next;
    end
  end

  always_comb begin
    state_next    = state;
    last_act_next = last_act;
    close         = 1'b0;
    cmd           = '0;
    in_stall      = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          close         = req_type ? last_act : (last_act && !in_actuate);
          last_act_next = req_type ? 1'b0 : in_actuate;
          if (close) begin
            cmd.hash_start = 1'b1;
            state_next     = status.len_zero ? S_EMIT : S_HRD;
          end else if (status.merge_ok) begin
            state_next = S_MRD;
          end
        end
      end
      S_MRD: begin
        cmd.merge_rd = 1'b1;
        state_next   = S_MWR;
      end
      S_MWR: begin
        cmd.merge_wr = 1'b1;
        state_next   = S_IDLE;
      end
      S_HRD: begin
        cmd.hash_rd = 1'b1;
        state_next  = S_HBYTE;
      end
      S_HBYTE: begin
        cmd.hash_step = 1'b1;
        if (status.hash_last) begin
          state_next = S_EMIT;
        end else if (status.row_end) begin
          state_next = S_HRD;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/rwim_datapath.sv
module rwim_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rwim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwim_pkg::ADDR_W-1:0]         cfg_data,
  input  logic                                req_type,
  input  logic                                in_actuate,
  input  logic                                is_response,
  input  logic [rwim_pkg::ADDR_W-1:0]         addr,
  input  logic [rwim_pkg::CNT_W-1:0]          byte_count,
  input  logic [rwim_pkg::DATA_W-1:0]         data,
  input  rwim_pkg::rwim_cmd_t                 cmd,
  output rwim_pkg::rwim_status_t              status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rwim_pkg::SUM_W-1:0]          checksum,
  output logic                                checksum_valid,
  output logic                                corrupted,
  output logic [rwim_pkg::FRAMES_W-1:0]       frames_corrupted
);

  localparam int LEN_W  = rwim_pkg::LEN_W;
  localparam int LANE_W = rwim_pkg::LANE_W;
  localparam int ROW_W  = rwim_pkg::ROW_W;
  localparam int ADDR_W = rwim_pkg::ADDR_W;

  // configuration
  logic [ADDR_W-1:0] region_base;
  logic [LEN_W-1:0]  region_len;
  logic              responses_only;
  logic [LEN_W-1:0]  n_len;
  logic              len_wr;

  // captured beat
  logic [ADDR_W-1:0]              diff_q;
  logic [rwim_pkg::DATA_W-1:0]    data_q;
  logic [rwim_pkg::CNT_W-1:0]     cnt_q;

  // snapshot valid bits, one per byte
  logic [rwim_pkg::SNAP_BYTES-1:0] vld;

  // per-lane views
  logic [7:0]       lane_byte  [rwim_pkg::LANES];
  logic             lane_diff  [rwim_pkg::LANES];
  logic [ROW_W-1:0] wr_row_w   [rwim_pkg::LANES];
  logic             wr_en_w    [rwim_pkg::LANES];
  logic [rwim_pkg::LANES-1:0] diff_vec;

  // hash walk
  logic [rwim_pkg::SUM_W-1:0] hash;
  logic [rwim_pkg::SUM_W-1:0] hash_next;
  logic [rwim_pkg::SUM_W-1:0] hash_x;
  logic [LEN_W-1:0]           hash_idx;
  logic [7:0]                 hash_byte;

  logic                          dirty;
  logic [rwim_pkg::FRAMES_W-1:0] frame_cnt;
  logic [rwim_pkg::FRAMES_W-1:0] frame_cnt_next;

  assign len_wr = cfg_write && (cfg_index == rwim_pkg::REG_REGION_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base    <= '0;
      region_len     <= '0;
      responses_only <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rwim_pkg::REG_REGION_BASE:    region_base    <= cfg_data;
        rwim_pkg::REG_REGION_LEN:     region_len     <= cfg_data[LEN_W-1:0];
        rwim_pkg::REG_RESPONSES_ONLY: responses_only <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign n_len = (region_len > LEN_W'(rwim_pkg::SNAP_BYTES)) ?
                 LEN_W'(rwim_pkg::SNAP_BYTES) : region_len;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_q <= addr - region_base;
      data_q <= data;
      cnt_q  <= (byte_count > rwim_pkg::CNT_W'(rwim_pkg::BEAT_BYTES)) ?
                rwim_pkg::CNT_W'(rwim_pkg::BEAT_BYTES) : byte_count;
    end
  end

  for (genvar b = 0; b < rwim_pkg::LANES; b++) begin : g_lane
    logic [7:0]        bank [rwim_pkg::ROWS];
    logic [LANE_W-1:0] sel;
    logic [LEN_W:0]    sum;
    logic              hi_zero;
    logic              in_rng;
    logic [ROW_W-1:0]  m_row;
    logic [ROW_W-1:0]  rd_row;
    logic [7:0]        rd_data;
    logic              rd_vld;
    logic [ROW_W-1:0]  wr_row;
    logic [7:0]        wr_byte;
    logic              wr_en;

    // beat byte that lands in this lane, and its offset in the region
    assign sel     = LANE_W'(b) - diff_q[LANE_W-1:0];
    assign sum     = {1'b0, diff_q[LEN_W-1:0]} + (LEN_W + 1)'(sel);
    assign hi_zero = sum[LEN_W] ? (&diff_q[ADDR_W-1:LEN_W]) : ~(|diff_q[ADDR_W-1:LEN_W]);
    assign in_rng  = hi_zero && (sum[LEN_W-1:0] < n_len) &&
                     ({1'b0, sel} < cnt_q);
    assign m_row   = sum[ROW_W+LANE_W-1:LANE_W];
    assign rd_row  = cmd.hash_rd ? hash_idx[ROW_W+LANE_W-1:LANE_W] : m_row;

    always_ff @(posedge clk) begin
      if (cmd.hash_rd || cmd.merge_rd) begin
        rd_data <= bank[rd_row];
        rd_vld  <= vld[{rd_row, LANE_W'(b)}];
      end
      if (cmd.merge_rd) begin
        wr_row  <= m_row;
        wr_byte <= data_q[{sel, 3'b000} +: 8];
        wr_en   <= in_rng;
      end
      if (cmd.merge_wr && wr_en) begin
        bank[wr_row] <= wr_byte;
      end
    end

    assign lane_byte[b] = rd_vld ? rd_data : 8'h00;
    assign lane_diff[b] = wr_en && (lane_byte[b] != wr_byte);
    assign wr_row_w[b]  = wr_row;
    assign wr_en_w[b]   = wr_en;
    assign diff_vec[b]  = lane_diff[b];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit || len_wr) begin
      vld <= '0;
    end else if (cmd.merge_wr) begin
      for (int b = 0; b < rwim_pkg::LANES; b++) begin
        if (wr_en_w[b]) begin
          vld[{wr_row_w[b], LANE_W'(b)}] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      dirty <= 1'b0;
    end else if (cmd.merge_wr && (|diff_vec)) begin
      dirty <= 1'b1;
    end
  end

  // one FNV-1a round: xor the byte, multiply by 2^40 + 435
  assign hash_byte = lane_byte[hash_idx[LANE_W-1:0]];
  assign hash_x    = hash ^ {56'd0, hash_byte};
  assign hash_next = (hash_x << rwim_pkg::FNV_SHIFT) + (hash_x * rwim_pkg::FNV_PRIME_LO);

  always_ff @(posedge clk) begin
    if (cmd.hash_start) begin
      hash     <= rwim_pkg::FNV_OFFSET;
      hash_idx <= '0;
    end else if (cmd.hash_step) begin
      hash     <= hash_next;
      hash_idx <= hash_idx + 1'b1;
    end
  end

  assign frame_cnt_next = (dirty && (frame_cnt != '1)) ? frame_cnt + 1'b1 : frame_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt <= '0;
    end else if (cmd.emit) begin
      frame_cnt <= frame_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      checksum         <= status.len_zero ? '0 : hash;
      checksum_valid   <= !status.len_zero;
      corrupted        <= dirty;
      frames_corrupted <= frame_cnt_next;
    end
  end

  always_comb begin
    status.merge_ok  = !req_type && in_actuate && (!responses_only || is_response) &&
                       (byte_count != '0);
    status.len_zero  = (n_len == '0);
    status.hash_last = (({1'b0, hash_idx} + 1'b1) == {1'b0, n_len});
    status.row_end   = &hash_idx[LANE_W-1:0];
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

// File: hw/rtl/region_write_integrity_monitor.sv
// Region write integrity monitor.
// Input channel (in_valid/in_stall) carries snooped memory beats and finish
// transactions; a transaction is taken when in_valid is high and in_stall low.
// During the actuate phase, beats (only responses when responses_only is set)
// merge the bytes in [region_base, region_base + min(region_len, 64)) into
// a 64-byte snapshot; any changed byte marks the frame corrupted.
// Leaving actuate, or a finish while in actuate, closes the frame: one result
// transaction on the output channel with the FNV-1a 64 hash of the watched
// bytes, a valid flag, the corrupted flag and a saturating corrupted-frame
// count. The snapshot and the flag are then cleared.
// A beat that merges nothing leaves the block idle; a merging beat reads the
// banks, then compares and writes. A close folds the watched bytes into the
// hash one byte per cycle, reading a bank row before every eight, then loads
// the result into the output register. A stalled result is held there; the
// block keeps taking transactions and only waits if a second result is ready.
// Configuration (cfg_write/cfg_index/cfg_data) is to be written while idle;
// the block itself does not enforce it. Writing region_len clears the
// snapshot. Reset clears the snapshot, flags, count and returns the registers
// to base 0, length 0, responses_only 1.
module region_write_integrity_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rwim_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwim_pkg::ADDR_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic                                in_actuate,
  input  logic                                is_response,
  input  logic [rwim_pkg::ADDR_W-1:0]         addr,
  input  logic [rwim_pkg::CNT_W-1:0]          byte_count,
  input  logic [rwim_pkg::DATA_W-1:0]         data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rwim_pkg::SUM_W-1:0]          checksum,
  output logic                                checksum_valid,
  output logic                                corrupted,
  output logic [rwim_pkg::FRAMES_W-1:0]       frames_corrupted
);

  rwim_pkg::rwim_cmd_t    cmd;
  rwim_pkg::rwim_status_t status;

  rwim_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .in_actuate (in_actuate),
    .status     (status),
    .cmd        (cmd)
  );

  rwim_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_type         (req_type),
    .in_actuate       (in_actuate),
    .is_response      (is_response),
    .addr             (addr),
    .byte_count       (byte_count),
    .data             (data),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .checksum         (checksum),
    .checksum_valid   (checksum_valid),
    .corrupted        (corrupted),
    .frames_corrupted (frames_corrupted)
  );

`ifndef SYNTHESIS
  a_zero_len_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !checksum_valid) |-> (checksum == '0))
    else $error("checksum nonzero for an empty region");

  a_corrupt_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && corrupted) |-> (frames_corrupted != '0))
    else $error("corrupted frame with zero count");

  a_actuate_no_close: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !req_type && in_actuate) |=> !$rose(out_valid))
    else $error("actuate beat closed a frame");
`endif

endmodule

// File: sim/tb_region_write_integrity_monitor.sv
module tb_region_write_integrity_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  import rwim_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic BEAT_ACCESS = 1'b0;
  localparam logic BEAT_FINISH = 1'b1;
  localparam logic [SUM_W-1:0] HASH_SEED   = 64'hCBF2_9CE4_8422_2325;
  localparam logic [SUM_W-1:0] FNV1A_PRIME = 64'd1099511628211;
  localparam int BEATS_PER_PHASE = 50;
  localparam int RANDOM_PHASES   = 10;
  localparam int DRAIN_CYCLES    = 100;

  typedef struct packed {
    logic              req_type;
    logic              in_actuate;
    logic              is_response;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  byte_count;
    logic [DATA_W-1:0] data;
  } snoop_beat_t;

  typedef struct packed {
    logic [SUM_W-1:0]    checksum;
    logic                checksum_valid;
    logic                corrupted;
    logic [FRAMES_W-1:0] frames_corrupted;
  } frame_sum_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 req_type = 1'b0;
  logic                 in_actuate = 1'b0;
  logic                 is_response = 1'b0;
  logic [ADDR_W-1:0]    addr = '0;
  logic [CNT_W-1:0]     byte_count = '0;
  logic [DATA_W-1:0]    data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SUM_W-1:0]     checksum;
  logic                 checksum_valid;
  logic                 corrupted;
  logic [FRAMES_W-1:0]  frames_corrupted;

  // shadow copy of the monitor's registers and state
  logic [ADDR_W-1:0]   shadow_base = '0;
  logic [LEN_W-1:0]    shadow_len = '0;
  logic                shadow_resp_only = 1'b1;
  logic [7:0]          shadow_snap [SNAP_BYTES];
  logic                shadow_dirty = 1'b0;
  logic                shadow_in_frame = 1'b0;
  logic [FRAMES_W-1:0] shadow_frames = '0;

  snoop_beat_t beats_to_send [$];
  frame_sum_t  frame_sums_due [$];
  int unsigned failures = 0;
  int unsigned phase_beats = 0;
  logic        calm = 1'b0;

  region_write_integrity_monitor dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .in_actuate(in_actuate), .is_response(is_response),
    .addr(addr), .byte_count(byte_count), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .checksum(checksum), .checksum_valid(checksum_valid),
    .corrupted(corrupted), .frames_corrupted(frames_corrupted)
  );

  always #10 clk = ~clk;

  function automatic int unsigned watched_bytes();
    return (shadow_len > LEN_W'(SNAP_BYTES)) ? SNAP_BYTES : int'(shadow_len);
  endfunction

  function void clear_snapshot();
    foreach (shadow_snap[i]) shadow_snap[i] = 8'h00;
  endfunction

  function void close_frame();
    frame_sum_t  s;
    int unsigned n;
    int          i;
    logic [SUM_W-1:0] h;
    n = watched_bytes();
    h = HASH_SEED;
    for (i = 0; i < n; i++) begin
      h = (h ^ SUM_W'(shadow_snap[i])) * FNV1A_PRIME;
    end
    s.checksum = (n == 0) ? '0 : h;
    s.checksum_valid = (n != 0);
    s.corrupted = shadow_dirty;
    if (shadow_dirty && shadow_frames != '1) shadow_frames++;
    s.frames_corrupted = shadow_frames;
    frame_sums_due.push_back(s);
    clear_snapshot();
    shadow_dirty = 1'b0;
  endfunction

  function void apply_beat(input snoop_beat_t b);
    int unsigned      lanes;
    int               i;
    logic [ADDR_W-1:0] off;
    if (b.req_type == BEAT_FINISH) begin
      if (shadow_in_frame) begin
        close_frame();
        shadow_in_frame = 1'b0;
      end
    end else begin
      if (shadow_in_frame && !b.in_actuate) close_frame();
      shadow_in_frame = b.in_actuate;
      if (b.in_actuate && (!shadow_resp_only || b.is_response) && b.byte_count != 0) begin
        lanes = (b.byte_count > BEAT_BYTES) ? BEAT_BYTES : int'(b.byte_count);
        for (i = 0; i < lanes; i++) begin
          // offsets wrap modulo 2^64 like the addresses
          off = b.addr + ADDR_W'(i) - shadow_base;
          if (off < ADDR_W'(watched_bytes())) begin
            if (shadow_snap[off[5:0]] != b.data[8*i +: 8]) shadow_dirty = 1'b1;
            shadow_snap[off[5:0]] = b.data[8*i +: 8];
          end
        end
      end
    end
  endfunction

  function void push_beat(input logic rt, input logic act, input logic resp,
                          input logic [ADDR_W-1:0] a, input logic [CNT_W-1:0] bc,
                          input logic [DATA_W-1:0] d);
    snoop_beat_t b;
    b = '{rt, act, resp, a, bc, d};
    beats_to_send.push_back(b);
    phase_beats++;
  endfunction

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // beat near the watched region, spilling a little past either end
  function void push_region_beat(input logic act);
    logic [CNT_W-1:0]  bc;
    logic [DATA_W-1:0] d;
    bc = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 15))
                                     : CNT_W'($urandom_range(1, 8));
    d = ($urandom_range(0, 3) == 0) ? '0 : rand64();
    push_beat(BEAT_ACCESS, act, $urandom_range(0, 9) != 0,
              shadow_base + ADDR_W'($urandom_range(0, int'(shadow_len) + 16)) - 64'd8,
              bc, d);
  endfunction

  function void push_noise_beat(input logic rt);
    push_beat(rt, 1'($urandom), 1'($urandom), rand64(), CNT_W'($urandom), rand64());
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_REGION_BASE: shadow_base = value;
      REG_REGION_LEN: begin
        shadow_len = value[LEN_W-1:0];
        clear_snapshot();
      end
      REG_RESPONSES_ONLY: shadow_resp_only = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // hold until every result is in and the block has gone quiet
  task automatic settle();
    while (beats_to_send.size() != 0 || frame_sums_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_beats
    snoop_beat_t cur;
    logic        taken;
    logic        go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        cur = beats_to_send.pop_front();
        apply_beat(cur);
      end
      if (!in_valid || taken) begin
        go = (beats_to_send.size() != 0) && (calm || $urandom_range(0, 99) >= 38);
        if (go) begin
          cur = beats_to_send[0];
          req_type    <= cur.req_type;
          in_actuate  <= cur.in_actuate;
          is_response <= cur.is_response;
          addr        <= cur.addr;
          byte_count  <= cur.byte_count;
          data        <= cur.data;
        end
        in_valid <= go;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < 38);
  end

  always @(posedge clk) begin : check_frames
    frame_sum_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_sums_due.size() == 0) begin
        $error("unexpected frame result: checksum %h", checksum);
        failures++;
      end else begin
        want = frame_sums_due.pop_front();
        if (checksum !== want.checksum) begin
          $error("checksum: expected %h, actual %h", want.checksum, checksum);
          failures++;
        end
        if (checksum_valid !== want.checksum_valid) begin
          $error("checksum_valid: expected %b, actual %b", want.checksum_valid, checksum_valid);
          failures++;
        end
        if (corrupted !== want.corrupted) begin
          $error("corrupted: expected %b, actual %b", want.corrupted, corrupted);
          failures++;
        end
        if (frames_corrupted !== want.frames_corrupted) begin
          $error("frames_corrupted: expected %0d, actual %0d",
                 want.frames_corrupted, frames_corrupted);
          failures++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned p;
    int unsigned k;
    int unsigned sel;
    logic [ADDR_W-1:0] base;
    clear_snapshot();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // region straddles the top of the address space
    write_reg(REG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFC);
    write_reg(REG_REGION_LEN, 64'd16);
    @(negedge clk);
    push_beat(BEAT_ACCESS, 1, 1, 64'hFFFF_FFFF_FFFF_FFF8, 4'd8, '1);
    push_beat(BEAT_ACCESS, 1, 1, 64'hFFFF_FFFF_FFFF_FFFE, 4'd8, rand64());
    push_beat(BEAT_ACCESS, 1, 0, 64'hFFFF_FFFF_FFFF_FFFC, 4'd4, rand64());
    push_beat(BEAT_ACCESS, 1, 1, 64'h0000_0000_0000_0004, 4'd15, rand64());
    push_beat(BEAT_ACCESS, 1, 1, 64'h0000_0000_0000_0000, 4'd0, '1);
    push_beat(BEAT_ACCESS, 0, 1, 64'h0000_0000_0000_0000, 4'd8, '1);
    push_beat(BEAT_FINISH, 1, 1, '1, 4'd8, '1);
    push_beat(BEAT_ACCESS, 1, 1, 64'h0000_0000_0000_0008, 4'd8, '0);
    push_noise_beat(BEAT_FINISH);
    push_beat(BEAT_FINISH, 0, 0, '0, 4'd0, '0);
    push_beat(BEAT_ACCESS, 1, 1, 64'hFFFF_FFFF_FFFF_FFFC, 4'd1, 64'h5A);
    settle();

    // the still-open dirty frame closes under a zero length
    write_reg(REG_REGION_LEN, {rand64() & ~64'h7F});
    write_reg(REG_RESPONSES_ONLY, 64'd0);
    @(negedge clk);
    push_beat(BEAT_ACCESS, 0, 0, '0, 4'd8, '1);
    push_beat(BEAT_ACCESS, 1, 0, '0, 4'd8, '1);
    push_beat(BEAT_ACCESS, 0, 1, '1, 4'd0, '0);
    settle();

    // region longer than the snapshot
    write_reg(REG_REGION_BASE, 64'd0);
    write_reg(REG_REGION_LEN, {rand64() & ~64'h7F} | 64'd100);
    write_reg(REG_SPARE, '1);
    @(negedge clk);
    push_beat(BEAT_ACCESS, 1, 1, 64'd0, 4'd8, '1);
    push_beat(BEAT_ACCESS, 1, 0, 64'd56, 4'd8, rand64());
    push_beat(BEAT_ACCESS, 1, 1, 64'd60, 4'd8, '1);
    push_beat(BEAT_ACCESS, 1, 1, '1, 4'd8, rand64());
    push_beat(BEAT_FINISH, 0, 0, '0, 4'd0, '0);
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      sel = $urandom_range(0, 3);
      base = (sel == 0) ? '0
           : (sel == 1) ? 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 70))
           : rand64();
      write_reg(REG_REGION_BASE, base);
      sel = $urandom_range(0, 9);
      write_reg(REG_REGION_LEN, (rand64() & ~64'h7F) |
                64'((sel == 0) ? 0 : (sel == 1) ? 64 :
                    (sel == 2) ? $urandom_range(65, 127) : $urandom_range(1, 24)));
      if ($urandom_range(0, 2) != 0) write_reg(REG_RESPONSES_ONLY, rand64());
      if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, rand64());
      @(negedge clk);
      calm = (p == RANDOM_PHASES / 2);
      phase_beats = 0;
      while (phase_beats < BEATS_PER_PHASE) begin
        if ($urandom_range(0, 19) < 3) begin
          repeat ($urandom_range(1, 4)) push_noise_beat($urandom_range(0, 4) == 0);
        end else begin
          repeat ($urandom_range(0, 2)) push_region_beat(1'b0);
          k = $urandom_range(1, 8);
          repeat (k) push_region_beat(1'b1);
          if ($urandom_range(0, 1) == 0) push_noise_beat(BEAT_FINISH);
          else push_region_beat(1'b0);
        end
      end
      settle();
      calm = 1'b0;
    end

    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
